// ===== hw/rtl/pfe_pkg.sv =====
package pfe_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DIV_STEPS   = DATA_W;

  localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_MUL   = 8'h2A;
  localparam logic [CHAR_W-1:0] CHAR_DIV   = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_MOD   = 8'h25;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_ARITH,
    TOK_DIVIDE,
    TOK_OTHER
  } tok_e;

  typedef enum logic {
    RD_TOP,
    RD_SECOND
  } rd_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_B,
    S_RD_A,
    S_EXEC,
    S_DIV,
    S_DIV_FIX,
    S_WB,
    S_FINISH,
    S_TOP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic    load;
    logic    push;
    logic    flag_over;
    logic    flag_under;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    capture_b;
    logic    capture_a;
    logic    exec_start;
    logic    div_step;
    logic    div_fix;
    logic    write_back;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    tok_e tok;
    logic last;
    logic full;
    logic lt2;
    logic b_zero;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/postfix_expression_evaluator.sv =====
// Postfix (RPN) evaluator, one character per input word.
// Input channel: in_valid_i/in_ready_o carry token_char_i and
// end_of_expression_i. Digits push, + - * / % pop two and push one,
// other characters are ignored. The word flagged end_of_expression
// produces one output word on out_valid_o/out_ready_i: value_o is the
// top of stack, status_o the first error of the expression (0 ok,
// 1 underflow, 2 overflow, 3 divide by zero).
// One word is processed at a time; in_ready_o is high only while idle.
// A digit or ignored char goes from decode to finish; + - * read both
// operands, execute and write back; / % also run a 32-step restoring
// divider and a sign fix, skipped on a zero divisor; an operator short
// of two operands is flagged and finishes. The final word also reads
// the top of stack, then out_valid_o rises with in_ready_o. The stack
// is a one-port-read memory, so each operator reads its operands one
// after the other. Reset clears the stack count, the error flag and the
// output valid flag; no clearing pass is needed. A result waits in the
// output register while the receiver stalls; the final word of the next
// expression then holds before emit until the register frees.
module postfix_expression_evaluator import pfe_pkg::*; #(
  parameter int unsigned StackDepth = STACK_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CHAR_W-1:0]        token_char_i,
  input  logic                     end_of_expression_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [1:0]               status_o
);

  cmd_t cmd;
  sts_t sts;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pfe_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .token_char_i        (token_char_i),
    .end_of_expression_i (end_of_expression_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .value_o             (value_o),
    .status_o            (status_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule

// ===== hw/rtl/pfe_ctrl.sv =====
module pfe_ctrl import pfe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (sts_i.tok)
          TOK_DIGIT: begin
            if (sts_i.full) begin
              cmd_o.flag_over = 1'b1;
            end else begin
              cmd_o.push = 1'b1;
            end
          end
          TOK_ARITH, TOK_DIVIDE: begin
            if (sts_i.lt2) begin
              cmd_o.flag_under = 1'b1;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_TOP;
              state_d      = S_RD_B;
            end
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_RD_B: begin
        cmd_o.capture_b = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_SECOND;
        state_d         = S_RD_A;
      end
      S_RD_A: begin
        cmd_o.capture_a = 1'b1;
        state_d         = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec_start = 1'b1;
        if (sts_i.tok == TOK_DIVIDE && !sts_i.b_zero) begin
          state_d = S_DIV;
        end else begin
          state_d = S_WB;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DIV_FIX;
        end
      end
      S_DIV_FIX: begin
        cmd_o.div_fix = 1'b1;
        state_d       = S_WB;
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.last) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_TOP;
          state_d      = S_TOP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TOP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/pfe_dp.sv =====
module pfe_dp import pfe_pkg::*; #(
  parameter int unsigned StackDepth = STACK_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CHAR_W-1:0]        token_char_i,
  input  logic                     end_of_expression_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [1:0]               status_o,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o
);

  localparam int unsigned AW  = $clog2(StackDepth);
  localparam int unsigned CW  = $clog2(StackDepth + 1);
  localparam int unsigned DCW = $clog2(DIV_STEPS);

  logic [DATA_W-1:0] stack_mem [StackDepth];
  logic [DATA_W-1:0] rdata_q;

  logic [CHAR_W-1:0] token_q;
  logic              last_q;
  logic [CW-1:0]     count_q, count_d;
  status_e           err_q, err_d;
  logic [DATA_W-1:0] a_q, b_q, res_q, rem_q, quo_q, mb_q;
  logic [DCW-1:0]    div_cnt_q;
  logic              out_valid_q;
  logic [DATA_W-1:0] value_q;
  status_e           status_q;

  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data, digit_val, mag_a, mag_b;
  logic              wr_en, is_digit, is_arith, is_divide, empty;
  logic [DATA_W:0]   div_shift, div_diff;
  status_e           flag_code;
  logic              flag_en;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign empty  = (count_q == '0);

  assign is_digit  = (token_q >= CHAR_0) && (token_q <= CHAR_9);
  assign is_arith  = (token_q == CHAR_PLUS) || (token_q == CHAR_MINUS) ||
                     (token_q == CHAR_MUL);
  assign is_divide = (token_q == CHAR_DIV) || (token_q == CHAR_MOD);
  assign digit_val = {{(DATA_W - CHAR_W){1'b0}}, token_q - CHAR_0};

  always_comb begin
    if (is_digit) begin
      sts_o.tok = TOK_DIGIT;
    end else if (is_arith) begin
      sts_o.tok = TOK_ARITH;
    end else if (is_divide) begin
      sts_o.tok = TOK_DIVIDE;
    end else begin
      sts_o.tok = TOK_OTHER;
    end
  end

  assign sts_o.last     = last_q;
  assign sts_o.full     = (count_q >= CW'(StackDepth));
  assign sts_o.lt2      = (count_q < CW'(2));
  assign sts_o.b_zero   = (b_q == '0);
  assign sts_o.div_last = (div_cnt_q == DCW'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign rd_addr = (cmd_i.rd_sel == RD_TOP) ? cnt_m1[AW-1:0] : cnt_m2[AW-1:0];
  assign wr_en   = cmd_i.push || cmd_i.write_back;
  assign wr_addr = cmd_i.push ? count_q[AW-1:0] : cnt_m2[AW-1:0];
  assign wr_data = cmd_i.push ? digit_val : res_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= stack_mem[rd_addr];
    end
  end

  assign mag_a     = a_q[DATA_W-1] ? (DATA_W'(0) - a_q) : a_q;
  assign mag_b     = b_q[DATA_W-1] ? (DATA_W'(0) - b_q) : b_q;
  assign div_shift = {rem_q, quo_q[DATA_W-1]};
  assign div_diff  = div_shift - {1'b0, mb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      token_q <= token_char_i;
      last_q  <= end_of_expression_i;
    end
    if (cmd_i.capture_b) begin
      b_q <= rdata_q;
    end
    if (cmd_i.capture_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.exec_start) begin
      if (is_divide) begin
        res_q     <= '0;
        rem_q     <= '0;
        quo_q     <= mag_a;
        mb_q      <= mag_b;
        div_cnt_q <= '0;
      end else if (token_q == CHAR_PLUS) begin
        res_q <= a_q + b_q;
      end else if (token_q == CHAR_MINUS) begin
        res_q <= a_q - b_q;
      end else begin
        res_q <= a_q * b_q;
      end
    end
    if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + DCW'(1);
      if (!div_diff[DATA_W]) begin
        rem_q <= div_diff[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= div_shift[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
    if (cmd_i.div_fix) begin
      if (token_q == CHAR_DIV) begin
        res_q <= (a_q[DATA_W-1] ^ b_q[DATA_W-1]) ? (DATA_W'(0) - quo_q) : quo_q;
      end else begin
        res_q <= a_q[DATA_W-1] ? (DATA_W'(0) - rem_q) : rem_q;
      end
    end
    if (cmd_i.emit) begin
      value_q  <= empty ? '0 : rdata_q;
      status_q <= (err_q != ST_OK) ? err_q : (empty ? ST_UNDER : ST_OK);
    end
  end

  always_comb begin
    flag_en   = 1'b0;
    flag_code = ST_OK;
    if (cmd_i.flag_over) begin
      flag_en   = 1'b1;
      flag_code = ST_OVER;
    end else if (cmd_i.flag_under) begin
      flag_en   = 1'b1;
      flag_code = ST_UNDER;
    end else if (cmd_i.exec_start && is_divide && b_q == '0) begin
      flag_en   = 1'b1;
      flag_code = ST_DIVZ;
    end
  end

  always_comb begin
    count_d = count_q;
    err_d   = err_q;
    if (cmd_i.emit) begin
      count_d = '0;
      err_d   = ST_OK;
    end else begin
      if (cmd_i.push) begin
        count_d = count_q + CW'(1);
      end else if (cmd_i.write_back) begin
        count_d = cnt_m1;
      end
      if (flag_en && err_q == ST_OK) begin
        err_d = flag_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      err_q   <= err_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// ===== hw/rtl/pfe_checker.sv =====
module pfe_checker import pfe_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [DATA_W-1:0] value_o,
  input logic [1:0]               status_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o) && $stable(status_o))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready while a word is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("output word raised without work in progress");

endmodule

bind postfix_expression_evaluator pfe_checker u_pfe_checker (.*);

// ===== tb/sv/postfix_expression_evaluator_test.sv =====
module postfix_expression_evaluator_test;
  import pfe_pkg::*;

  class rpn_scoreboard;
    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int unsigned       depth;
    status_e           first_error;
    logic [DATA_W-1:0] result_values [$];
    status_e           result_codes [$];
    int unsigned       mismatches;

    function new();
      depth = 0;
      first_error = ST_OK;
      mismatches = 0;
    endfunction

    function void raise(status_e code);
      if (first_error == ST_OK) begin
        first_error = code;
      end
    endfunction

    function logic [DATA_W-1:0] arith(logic [CHAR_W-1:0] ch, logic [DATA_W-1:0] a,
                                      logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] mag_a, mag_b, quo, rem;
      if (ch == CHAR_PLUS) begin
        return a + b;
      end
      if (ch == CHAR_MINUS) begin
        return a - b;
      end
      if (ch == CHAR_MUL) begin
        return a * b;
      end
      if (b == '0) begin
        raise(ST_DIVZ);
        return '0;
      end
      mag_a = a[DATA_W-1] ? '0 - a : a;
      mag_b = b[DATA_W-1] ? '0 - b : b;
      if (ch == CHAR_DIV) begin
        quo = mag_a / mag_b;
        return (a[DATA_W-1] ^ b[DATA_W-1]) ? '0 - quo : quo;
      end
      rem = mag_a % mag_b;
      return a[DATA_W-1] ? '0 - rem : rem;
    endfunction

    function void note_word(logic [CHAR_W-1:0] ch, logic last);
      logic [DATA_W-1:0] a, b, top;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
        if (depth >= STACK_DEPTH) begin
          raise(ST_OVER);
        end else begin
          operands[depth] = DATA_W'(ch - CHAR_0);
          depth++;
        end
      end else if (ch == CHAR_PLUS || ch == CHAR_MINUS || ch == CHAR_MUL ||
                   ch == CHAR_DIV || ch == CHAR_MOD) begin
        if (depth < 2) begin
          raise(ST_UNDER);
        end else begin
          b = operands[depth-1];
          a = operands[depth-2];
          depth--;
          operands[depth-1] = arith(ch, a, b);
        end
      end
      if (last) begin
        top = '0;
        if (depth >= 1) begin
          top = operands[depth-1];
        end else begin
          raise(ST_UNDER);
        end
        result_values.push_back(top);
        result_codes.push_back(first_error);
        depth = 0;
        first_error = ST_OK;
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] value, logic [1:0] status);
      logic [DATA_W-1:0] want_value;
      status_e           want_code;
      if (result_values.size() == 0) begin
        $error("value: expected none, got %0d", $signed(value));
        mismatches++;
        return;
      end
      want_value = result_values.pop_front();
      want_code = result_codes.pop_front();
      if (value !== want_value) begin
        $error("value: expected %0d, got %0d", $signed(want_value), $signed(value));
        mismatches++;
      end
      if (status !== want_code) begin
        $error("status: expected %0d, got %0d", want_code, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return result_values.size();
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [CHAR_W-1:0]        token_char_i;
  logic                     end_of_expression_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [DATA_W-1:0] value_o;
  logic [1:0]               status_o;

  rpn_scoreboard     sb;
  logic [CHAR_W-1:0] expr_chars [$];
  int unsigned       words_sent;
  bit                quiet_phase;
  bit                sender_calm;

  postfix_expression_evaluator u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .token_char_i        (token_char_i),
    .end_of_expression_i (end_of_expression_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .value_o             (value_o),
    .status_o            (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit is_token(logic [CHAR_W-1:0] c);
    return (c >= CHAR_0 && c <= CHAR_9) || c == CHAR_PLUS || c == CHAR_MINUS ||
           c == CHAR_MUL || c == CHAR_DIV || c == CHAR_MOD;
  endfunction

  function automatic logic [CHAR_W-1:0] pick_op();
    case ($urandom_range(0, 4))
      0: return CHAR_PLUS;
      1: return CHAR_MINUS;
      2: return CHAR_MUL;
      3: return CHAR_DIV;
      default: return CHAR_MOD;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_other();
    logic [CHAR_W-1:0] c;
    c = CHAR_W'($urandom_range(0, 255));
    while (is_token(c)) begin
      c = CHAR_W'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic last);
    if (!quiet_phase && !sender_calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    token_char_i <= ch;
    end_of_expression_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(token_char_i, end_of_expression_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    sender_calm = ($urandom_range(0, 2) == 0);
    foreach (expr_chars[i]) begin
      send_word(expr_chars[i], i == expr_chars.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    expr_chars = {};
    for (int i = 0; i < s.len(); i++) begin
      expr_chars.push_back(s[i]);
    end
    send_expr();
  endtask

  task automatic build_rpn();
    int depth, pushed, n_dig;
    expr_chars = {};
    depth = 0;
    pushed = 0;
    n_dig = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 7);
    while (pushed < n_dig || depth > 1) begin
      if ($urandom_range(0, 24) == 0) begin
        expr_chars.push_back(pick_other());
      end
      if (pushed < n_dig && (depth < 2 || $urandom_range(0, 2) != 0)) begin
        expr_chars.push_back(CHAR_W'(CHAR_0 + $urandom_range(0, 9)));
        pushed++;
        if (depth < STACK_DEPTH) begin
          depth++;
        end
      end else begin
        expr_chars.push_back(pick_op());
        depth--;
      end
    end
  endtask

  task automatic build_noise();
    int n;
    expr_chars = {};
    n = $urandom_range(1, 10);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: expr_chars.push_back(CHAR_W'(CHAR_0 + $urandom_range(0, 9)));
        1: expr_chars.push_back(pick_op());
        default: expr_chars.push_back(CHAR_W'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin : sink_ready
    int unsigned stall_left, cycle_n;
    bit          calm;
    stall_left = 0;
    cycle_n = 0;
    calm = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cycle_n++;
      if (cycle_n % 300 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rst_ni && !quiet_phase && !calm && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 15) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_result(value_o, status_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned random_start, pick;
    sb = new();
    words_sent = 0;
    quiet_phase = 1'b0;
    sender_calm = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    token_char_i = '0;
    end_of_expression_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    expr_chars = {8'h00, CHAR_9, 8'hFF};
    send_expr();
    send_text("0");
    send_text("34+");
    send_text("35-");
    send_text("78*");
    send_text("07-2/");
    send_text("807-%");
    send_text("50/");
    send_text("50%");
    send_text("+");
    send_text("3+");
    send_text("+50/");
    send_text("a");
    send_text("12");
    send_text("11111111111111111+");
    send_text("88*8*8*8*8*8*8*8*8*2*01-/");
    send_text("88*8*8*8*8*8*8*8*8*2*01-%");

    random_start = words_sent;
    while (words_sent - random_start < 1200) begin
      if (words_sent - random_start >= 1050) begin
        quiet_phase = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        build_rpn();
      end else if (pick < 88) begin
        build_rpn();
        while (expr_chars.size() > 1 && $urandom_range(0, 1) == 0) begin
          void'(expr_chars.pop_back());
        end
      end else begin
        build_noise();
      end
      send_expr();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
